// ===== src/truncated_mean_dedx_top_macros.svh =====
// Assertion helpers for the truncated-mean block
`ifndef TRUNCATED_MEAN_DEDX_TOP_MACROS_SVH
`define TRUNCATED_MEAN_DEDX_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define TMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Plain invariant outside reset
`define TMD_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`endif

// ===== src/tmd_pkg.sv =====
package tmd_pkg;
	localparam int MaxSamples = 256;
	localparam int ChargeBits = 16;
	localparam int IdxBits = $clog2(MaxSamples);
	localparam int CntBits = IdxBits + 1;
	localparam int SumBits = ChargeBits + CntBits;
	localparam int DenBits = CntBits + 8;
	localparam int NumBits = SumBits + 7;
	localparam int QDepth = 2;
	localparam logic [7:0] TruncLowReset = 8'd2;
	localparam logic [7:0] TruncHighReset = 8'd77;
	localparam logic [0:0] RegTruncLow = 1'b0;
	localparam logic [0:0] RegTruncHigh = 1'b1;

	typedef struct packed {
		logic [ChargeBits-1:0] charge;
		logic has_sample;
		logic last;
	} in_item_t;

	typedef struct packed {
		logic [ChargeBits-1:0] mean_charge;
		logic [8:0] used_count;
		logic overflowed;
	} out_item_t;

	// front to back: one closed track
	typedef struct packed {
		logic [CntBits-1:0] n;
		logic ovf;
	} track_t;
endpackage

// ===== src/tmd_front.sv =====
// Front: insertion into the sorted store, closes tracks into the queue
module tmd_front (
	input logic clk,
	input logic arst_n,
	input tmd_pkg::in_item_t in_data,
	input logic in_valid,
	output logic in_ready,
	output logic tr_valid,
	output tmd_pkg::track_t tr_data,
	input logic tr_ready,
	input logic rd_en,
	input logic [tmd_pkg::IdxBits-1:0] rd_addr,
	output logic [tmd_pkg::ChargeBits-1:0] rd_data
);
	`include "truncated_mean_dedx_top_macros.svh"
	typedef enum logic [1:0] {IDLE, SCAN, SHIFT, HOLD} state_t;

	state_t state_q;
	logic [tmd_pkg::ChargeBits-1:0] mem [tmd_pkg::MaxSamples];
	logic [tmd_pkg::ChargeBits-1:0] mem_rd_q;
	logic [tmd_pkg::CntBits-1:0] cnt_q, pos_q, k_q;
	logic [tmd_pkg::ChargeBits-1:0] c_q;
	logic last_q, ovf_q;
	logic busy_rd_q;
	logic [tmd_pkg::IdxBits-1:0] addr;
	logic wr_en;
	logic [tmd_pkg::IdxBits-1:0] wr_addr;
	logic [tmd_pkg::ChargeBits-1:0] wr_data;

	assign in_ready = (state_q == IDLE);
	assign tr_valid = (state_q == HOLD);
	assign tr_data.n = cnt_q;
	assign tr_data.ovf = ovf_q;
	assign rd_data = mem_rd_q;

	// one read port: scan or shift address while inserting, back unit otherwise
	always_comb begin
		if (state_q == SCAN) begin
			addr = pos_q[tmd_pkg::IdxBits-1:0];
		end else if (state_q == SHIFT) begin
			addr = k_q[tmd_pkg::IdxBits-1:0] - 1'b1;
		end else begin
			addr = rd_addr;
		end
	end

	// store memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en || state_q == SCAN || state_q == SHIFT) begin
			mem_rd_q <= mem[addr];
		end
	end

	// write: shift entry k-1 up to k once read back, then place the sample
	always_comb begin
		wr_en = 1'b0;
		wr_addr = k_q[tmd_pkg::IdxBits-1:0];
		wr_data = mem_rd_q;
		if (state_q == SHIFT && busy_rd_q) begin
			wr_en = 1'b1;
		end else if (state_q == SHIFT && k_q == pos_q) begin
			wr_en = 1'b1;
			wr_data = c_q;
		end
	end

	// insertion sequencer: scan reads one entry at a time, shift likewise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			pos_q <= '0;
			k_q <= '0;
			last_q <= 1'b0;
			busy_rd_q <= 1'b0;
			c_q <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					busy_rd_q <= 1'b0;
					if (in_valid) begin
						c_q <= in_data.charge;
						last_q <= in_data.last;
						pos_q <= '0;
						if (in_data.has_sample &&
							cnt_q == tmd_pkg::CntBits'(tmd_pkg::MaxSamples)) begin
							ovf_q <= 1'b1;
							state_q <= in_data.last ? HOLD : IDLE;
						end else if (in_data.has_sample) begin
							state_q <= SCAN;
						end else begin
							state_q <= in_data.last ? HOLD : IDLE;
						end
					end
				end
				SCAN: begin
					if (!busy_rd_q) begin
						if (pos_q == cnt_q) begin
							k_q <= cnt_q;
							state_q <= SHIFT;
						end else begin
							busy_rd_q <= 1'b1;
						end
					end else begin
						busy_rd_q <= 1'b0;
						if (mem_rd_q <= c_q) begin
							pos_q <= pos_q + 1'b1;
						end else begin
							k_q <= cnt_q;
							state_q <= SHIFT;
						end
					end
				end
				SHIFT: begin
					if (busy_rd_q) begin
						busy_rd_q <= 1'b0;
						k_q <= k_q - 1'b1;
					end else if (k_q == pos_q) begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= last_q ? HOLD : IDLE;
					end else begin
						busy_rd_q <= 1'b1;
					end
				end
				HOLD: begin
					if (tr_ready) begin
						cnt_q <= '0;
						ovf_q <= 1'b0;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	`TMD_ASSERT_ALWAYS(a_cnt_range, clk, arst_n,
		cnt_q <= tmd_pkg::CntBits'(tmd_pkg::MaxSamples), "sample count beyond store")
	`TMD_ASSERT_IMP(a_pos_le_cnt, clk, arst_n, state_q == SHIFT,
		pos_q <= k_q && k_q <= cnt_q, "shift index out of order")
	`TMD_ASSERT_IMP(a_no_rd_busy, clk, arst_n, rd_en, state_q == IDLE || state_q == HOLD,
		"back read while inserting")
endmodule

// ===== src/tmd_queue.sv =====
// Short FIFO of closed tracks between front and back
module tmd_queue (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input tmd_pkg::track_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output tmd_pkg::track_t rd_data
);
	`include "truncated_mean_dedx_top_macros.svh"
	tmd_pkg::track_t slot_q [tmd_pkg::QDepth];
	logic [$clog2(tmd_pkg::QDepth):0] fill_q;
	logic wp_q, rp_q;

	assign wr_ready = fill_q != ($clog2(tmd_pkg::QDepth)+1)'(tmd_pkg::QDepth);
	assign rd_valid = fill_q != '0;
	assign rd_data = slot_q[rp_q];

	// slots
	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) begin
			slot_q[wp_q] <= wr_data;
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (wr_valid && wr_ready) begin
				wp_q <= ~wp_q;
			end
			if (rd_valid && rd_ready) begin
				rp_q <= ~rp_q;
			end
			if ((wr_valid && wr_ready) && !(rd_valid && rd_ready)) begin
				fill_q <= fill_q + 1'b1;
			end else if (!(wr_valid && wr_ready) && (rd_valid && rd_ready)) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	`TMD_ASSERT_ALWAYS(a_fill_range, clk, arst_n,
		fill_q <= ($clog2(tmd_pkg::QDepth)+1)'(tmd_pkg::QDepth), "queue overfilled")
	`TMD_ASSERT_IMP(a_ptr_match, clk, arst_n, fill_q == '0, wp_q == rp_q,
		"empty queue with split pointers")
	`TMD_ASSERT_IMP(a_no_underflow, clk, arst_n, fill_q == '0, !rd_valid,
		"valid from empty queue")
endmodule

// ===== src/tmd_back.sv =====
// Back: window bounds, window sum over the store, restoring divide
module tmd_back (
	input logic clk,
	input logic arst_n,
	input logic [7:0] trunc_low,
	input logic [7:0] trunc_high,
	input logic tr_valid,
	output logic tr_ready,
	input tmd_pkg::track_t tr_data,
	input logic front_idle,
	output logic store_busy,
	output logic rd_en,
	output logic [tmd_pkg::IdxBits-1:0] rd_addr,
	input logic [tmd_pkg::ChargeBits-1:0] rd_data,
	output logic out_valid,
	input logic out_ready,
	output tmd_pkg::out_item_t out_data
);
	`include "truncated_mean_dedx_top_macros.svh"
	localparam int DB = tmd_pkg::DenBits;
	localparam int NB = tmd_pkg::NumBits;
	localparam int CB = tmd_pkg::CntBits;
	typedef enum logic [2:0] {IDLE, PROD, BOUND, SUM, DIV, EMIT} state_t;

	state_t state_q;
	tmd_pkg::track_t tr_q;
	logic [DB-1:0] lo_prod_q, hi_prod_q, den_q;
	logic [CB-1:0] lo_q, hi_q, i_q;
	logic rd_pend_q;
	logic [tmd_pkg::SumBits-1:0] sum_q;
	logic [NB-1:0] num_q;
	logic [DB:0] rem_q;
	logic [$clog2(NB+1)-1:0] bit_q;
	logic [DB:0] rem_sh;
	logic [DB-1:0] hi_ceil;
	logic [DB-7-1:0] hi_div;

	assign tr_ready = (state_q == IDLE);
	assign out_valid = (state_q == EMIT);
	// the store still holds the track being summed
	assign store_busy = (state_q == PROD) || (state_q == BOUND) || (state_q == SUM);
	assign rd_en = (state_q == SUM) && !rd_pend_q && (i_q != hi_q) && front_idle;
	assign rd_addr = i_q[tmd_pkg::IdxBits-1:0];
	assign rem_sh = {rem_q[DB-1:0], num_q[NB-1]};
	assign hi_ceil = hi_prod_q + DB'(127);
	assign hi_div = hi_ceil[DB-1:7];

	// sequencer: products, bounds, serial sum, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			rd_pend_q <= 1'b0;
			tr_q <= '0;
			lo_prod_q <= '0;
			hi_prod_q <= '0;
			den_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			i_q <= '0;
			sum_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			bit_q <= '0;
			out_data <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (tr_valid) begin
						tr_q <= tr_data;
						state_q <= PROD;
					end
				end
				PROD: begin
					lo_prod_q <= DB'(tr_q.n) * DB'(trunc_low);
					hi_prod_q <= DB'(tr_q.n) * DB'(trunc_high);
					den_q <= DB'(tr_q.n) * DB'(trunc_high - trunc_low);
					state_q <= BOUND;
				end
				BOUND: begin
					out_data.used_count <= 9'(tr_q.n);
					out_data.overflowed <= tr_q.ovf;
					sum_q <= '0;
					rd_pend_q <= 1'b0;
					if (lo_prod_q >= hi_prod_q) begin
						out_data.mean_charge <= '0;
						state_q <= EMIT;
					end else begin
						lo_q <= (DB'(lo_prod_q[DB-1:7]) > DB'(tr_q.n)) ? tr_q.n
							: CB'(lo_prod_q[DB-1:7]);
						hi_q <= (DB'(hi_div) > DB'(tr_q.n)) ? tr_q.n : CB'(hi_div);
						i_q <= (DB'(lo_prod_q[DB-1:7]) > DB'(tr_q.n)) ? tr_q.n
							: CB'(lo_prod_q[DB-1:7]);
						state_q <= SUM;
					end
				end
				SUM: begin
					if (rd_pend_q) begin
						sum_q <= sum_q + tmd_pkg::SumBits'(rd_data);
						rd_pend_q <= 1'b0;
					end else if (i_q == hi_q) begin
						num_q <= {sum_q, 7'd0};
						rem_q <= '0;
						bit_q <= '0;
						state_q <= DIV;
					end else if (rd_en) begin
						rd_pend_q <= 1'b1;
						i_q <= i_q + 1'b1;
					end
				end
				DIV: begin
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= rem_sh - {1'b0, den_q};
						num_q <= {num_q[NB-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						num_q <= {num_q[NB-2:0], 1'b0};
					end
					bit_q <= bit_q + 1'b1;
					if (bit_q == $bits(bit_q)'(NB-1)) begin
						state_q <= EMIT;
					end
				end
				EMIT: begin
					if (out_ready) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
			// saturate the quotient to the charge range on the final step
			if (state_q == DIV && bit_q == $bits(bit_q)'(NB-1)) begin
				if (num_q[NB-2:tmd_pkg::ChargeBits-1] != '0) begin
					out_data.mean_charge <= '1;
				end else begin
					out_data.mean_charge <= {num_q[tmd_pkg::ChargeBits-2:0],
						(rem_sh >= {1'b0, den_q})};
				end
			end
		end
	end

	`TMD_ASSERT_IMP(a_div_nonzero, clk, arst_n, state_q == DIV, den_q != '0,
		"divide by zero")
	`TMD_ASSERT_IMP(a_sum_bounds, clk, arst_n, state_q == SUM, i_q <= hi_q,
		"sum index past window")
endmodule

// ===== src/truncated_mean_dedx_top.sv =====
// Truncated-mean dE/dx: sorted insertion front, windowed mean back.
// Insertion of a sample scans the held ones for its place, then shifts the larger ones up (one memory port).
// A closing item then passes the queue and the back's products, bounds, window sum and serial divide.
// The front takes the next track only once the back has finished reading the store.
// Reset (arst_n low, asynchronous) clears counts, queue and cuts to 2 and 77.
module truncated_mean_dedx_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input tmd_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output tmd_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [7:0] cfg_data
);
	logic [7:0] trunc_low_q, trunc_high_q;
	logic f_valid, f_ready, b_valid, b_ready, rd_en, front_in_ready;
	logic back_busy, store_free;
	tmd_pkg::track_t f_data, b_data;
	logic [tmd_pkg::IdxBits-1:0] rd_addr;
	logic [tmd_pkg::ChargeBits-1:0] rd_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trunc_low_q <= tmd_pkg::TruncLowReset;
			trunc_high_q <= tmd_pkg::TruncHighReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tmd_pkg::RegTruncLow: trunc_low_q <= cfg_data;
				tmd_pkg::RegTruncHigh: trunc_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the store is shared: no new transaction while a closed track still needs it
	assign store_free = !b_valid && !back_busy;
	assign in_ready = front_in_ready && store_free;

	tmd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_data(in_data), .in_valid(in_valid && store_free), .in_ready(front_in_ready),
		.tr_valid(f_valid), .tr_data(f_data), .tr_ready(f_ready),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
	);

	tmd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
		.rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
	);

	tmd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.trunc_low(trunc_low_q), .trunc_high(trunc_high_q),
		.tr_valid(b_valid), .tr_ready(b_ready), .tr_data(b_data),
		.front_idle(front_in_ready), .store_busy(back_busy),
		.rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

// ===== dv/tb_truncated_mean_dedx_top.sv =====
`timescale 1ns / 100ps

module tb_truncated_mean_dedx_top;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	tmd_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	tmd_pkg::out_item_t out_data;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [7:0] cfg_data;

	truncated_mean_dedx_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predictor state: sorted charges, count, overflow flag, cuts
	logic [tmd_pkg::ChargeBits-1:0] track_charges[tmd_pkg::MaxSamples];
	int unsigned held_count;
	bit drop_seen;
	logic [7:0] cut_low;
	logic [7:0] cut_high;

	tmd_pkg::in_item_t pending_items[$];
	tmd_pkg::out_item_t expected_means[$];
	int unsigned tracks_sent;
	int unsigned results_seen;
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	localparam int unsigned CycleLimit = 4000000;

	always #6 clk = ~clk;

	// Insert one charge in ascending order (after equal entries)
	task automatic hold_charge(input logic [tmd_pkg::ChargeBits-1:0] c);
		int unsigned pos;
		if (held_count >= tmd_pkg::MaxSamples) begin
			drop_seen = 1'b1;
			return;
		end
		pos = 0;
		while (pos < held_count && track_charges[pos] <= c)
			pos++;
		for (int unsigned k = held_count; k > pos; k--)
			track_charges[k] = track_charges[k-1];
		track_charges[pos] = c;
		held_count++;
	endtask

	function automatic logic [tmd_pkg::ChargeBits-1:0] window_mean_of_track();
		longint unsigned lo_prod, hi_prod, lo, hi, sum, den, q;
		lo_prod = longint'(held_count) * cut_low;
		hi_prod = longint'(held_count) * cut_high;
		if (lo_prod >= hi_prod)
			return '0;
		lo = lo_prod / 128;
		hi = (hi_prod + 127) / 128;
		if (lo > held_count)
			lo = held_count;
		if (hi > held_count)
			hi = held_count;
		sum = 0;
		for (longint unsigned i = lo; i < hi; i++)
			sum += track_charges[i];
		den = longint'(held_count) * (cut_high - cut_low);
		q = (sum * 128) / den;
		if (q > 65535)
			q = 65535;
		return q[tmd_pkg::ChargeBits-1:0];
	endfunction

	// Predict on every accepted transaction
	task automatic predict_item(input tmd_pkg::in_item_t it);
		tmd_pkg::out_item_t r;
		if (it.has_sample)
			hold_charge(it.charge);
		if (!it.last)
			return;
		r.mean_charge = window_mean_of_track();
		r.used_count = held_count[8:0];
		r.overflowed = drop_seen;
		expected_means.push_back(r);
		held_count = 0;
		drop_seen = 1'b0;
	endtask

	// Driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				predict_item(in_data);
			if (!in_valid || in_ready) begin
				if (in_valid && in_ready)
					void'(pending_items.pop_front());
				if (pending_items.size() > 0 &&
						$urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= pending_items[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_means.size() == 0) begin
					error_count++;
					$display("%0t: result expected none actual %p", $time, out_data);
				end else begin
					tmd_pkg::out_item_t e;
					e = expected_means.pop_front();
					if (out_data.mean_charge !== e.mean_charge) begin
						error_count++;
						$display("%0t: mean_charge expected %0d actual %0d", $time,
							e.mean_charge, out_data.mean_charge);
					end
					if (out_data.used_count !== e.used_count) begin
						error_count++;
						$display("%0t: used_count expected %0d actual %0d", $time,
							e.used_count, out_data.used_count);
					end
					if (out_data.overflowed !== e.overflowed) begin
						error_count++;
						$display("%0t: overflowed expected %0b actual %0b", $time,
							e.overflowed, out_data.overflowed);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic push_item(input logic [tmd_pkg::ChargeBits-1:0] c, input bit has,
			input bit lst);
		tmd_pkg::in_item_t it;
		it.charge = c;
		it.has_sample = has;
		it.last = lst;
		pending_items.push_back(it);
		if (lst)
			tracks_sent++;
	endtask

	// A track of n samples; charges drawn from the full range, a narrow low or high band, or 0 to 4095
	task automatic push_track(input int unsigned n, input bit end_marker);
		int unsigned mode;
		mode = $urandom_range(3);
		for (int unsigned i = 0; i < n; i++) begin
			logic [tmd_pkg::ChargeBits-1:0] c;
			case (mode)
				0: c = 16'($urandom_range(65535));
				1: c = 16'($urandom_range(7));
				2: c = 16'hFFF0 | 16'($urandom_range(15));
				default: c = 16'($urandom_range(4095));
			endcase
			if ($urandom_range(15) == 0)
				push_item(16'($urandom), 1'b0, 1'b0);
			push_item(c, 1'b1, !end_marker && i == n - 1);
		end
		if (end_marker || n == 0)
			push_item(16'($urandom), 1'b0, 1'b1);
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_means.size() > 0)
			@(posedge clk);
		// back end may still be idle-settling
		repeat (1200) @(posedge clk);
	endtask

	task automatic write_cut(input logic [0:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tmd_pkg::RegTruncLow)
			cut_low = val;
		else
			cut_high = val;
	endtask

	task automatic random_phase(input int unsigned items);
		int unsigned start;
		start = pending_items.size();
		while (pending_items.size() - start < items) begin
			int unsigned r;
			r = $urandom_range(99);
			if (r < 80)
				push_track($urandom_range(1, 12), $urandom_range(1));
			else if (r < 95)
				push_track($urandom_range(13, 40), $urandom_range(1));
			else
				push_item(16'($urandom), 1'b0, 1'b1);
		end
	endtask

	initial begin
		logic [7:0] lows[6];
		logic [7:0] highs[6];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = tmd_pkg::RegTruncLow;
		cfg_data = '0;
		held_count = 0;
		drop_seen = 1'b0;
		cut_low = tmd_pkg::TruncLowReset;
		cut_high = tmd_pkg::TruncHighReset;
		tracks_sent = 0;
		results_seen = 0;
		error_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset cuts, extremes, empty track, sample with last
		push_item(16'h0000, 1'b1, 1'b0);
		push_item(16'hFFFF, 1'b1, 1'b0);
		push_item(16'h8000, 1'b1, 1'b0);
		push_item(16'h1234, 1'b1, 1'b1);
		push_item(16'hFFFF, 1'b0, 1'b1);
		push_item(16'h5555, 1'b0, 1'b0);
		push_item(16'hAAAA, 1'b1, 1'b1);
		for (int i = 0; i < 6; i++)
			push_item(16'hFFFF, 1'b1, i == 5);
		drain();

		// Full store then dropped samples, default cuts
		push_track(tmd_pkg::MaxSamples + 3, 1'b0);
		push_track(tmd_pkg::MaxSamples, 1'b1);
		drain();

		// Narrow window: saturating mean; low >= high; cuts above 128
		lows = '{8'd0, 8'd127, 8'd100, 8'd60, 8'd255, 8'd130};
		highs = '{8'd128, 8'd128, 8'd40, 8'd61, 8'd255, 8'd255};
		for (int p = 0; p < 6; p++) begin
			write_cut(tmd_pkg::RegTruncLow, lows[p]);
			write_cut(tmd_pkg::RegTruncHigh, highs[p]);
			for (int t = 0; t < 4; t++)
				push_track($urandom_range(1, 9), 1'b0);
			push_item(16'hFFFF, 1'b1, 1'b0);
			push_item(16'hFFFF, 1'b1, 1'b1);
			drain();
		end

		// Random phases across idling patterns and cut settings
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 80 : 38) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 80 : 38) : 0;
			write_cut(tmd_pkg::RegTruncLow,
				$urandom_range(1) ? 8'($urandom_range(40)) : 8'($urandom));
			write_cut(tmd_pkg::RegTruncHigh,
				$urandom_range(1) ? 8'($urandom_range(60, 128)) : 8'($urandom));
			random_phase(250);
			drain();
		end

		$display("Covered %0d tracks, %0d results checked, cuts swept incl. extremes",
			tracks_sent, results_seen);
		$display("with full-store overflow and all idling patterns.");
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
